/* hw/rtl/sps_pkg.sv */
// sps_pkg: shared types and constants of the servo pulse scaler
// register map, configuration struct, controller/datapath command and status structs
// no dependencies
`default_nettype none

package sps_pkg;

	localparam int ADDR_W    = 5;
	localparam int DATA_W    = 32;
	localparam int REG_IDX_W = 3;

	// register indexes, byte address is 4 * index
	localparam logic [REG_IDX_W-1:0] REG_ENABLED   = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_WIDE_MODE = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_REVERSED  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_SCALED    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_MIN_US    = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MAX_US    = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_HOME      = 3'd6;
	localparam logic [REG_IDX_W-1:0] REG_RATE      = 3'd7;

	localparam logic        RST_ENABLED   = 1'b0;
	localparam logic        RST_WIDE_MODE = 1'b0;
	localparam logic        RST_REVERSED  = 1'b0;
	localparam logic        RST_SCALED    = 1'b1;
	localparam logic [15:0] RST_MIN_US    = 16'd1000;
	localparam logic [15:0] RST_MAX_US    = 16'd2000;
	localparam logic [15:0] RST_HOME      = 16'd0;
	localparam logic [10:0] RST_RATE      = 11'd50;

	// input spans
	localparam logic [16:0] SPAN_NARROW = 17'd255;
	localparam logic [16:0] SPAN_WIDE   = 17'd65535;

	// exact reciprocals for 32-bit dividends: n/255 and n/65535
	localparam logic [31:0] RECIP_NARROW = 32'h8080_8081;
	localparam int          SHIFT_NARROW = 39;
	localparam logic [31:0] RECIP_WIDE   = 32'h8000_8001;
	localparam int          SHIFT_WIDE   = 47;

	// ticks = floor(p * 4096 / 1e6) = floor(p * 64 / 15625) = (p * TICK_RECIP) >> 41
	// exact for p below 2^27
	localparam logic [33:0] TICK_RECIP   = 34'd9007199255;
	localparam int          TICK_SHIFT   = 41;
	localparam int          TICK_LO_W    = 17;
	localparam logic [16:0] TICK_RECIP_LO = TICK_RECIP[16:0];
	localparam logic [16:0] TICK_RECIP_HI = TICK_RECIP[33:17];

	typedef struct packed {
		logic        enabled;
		logic        wide_mode;
		logic        reversed;
		logic        scaled;
		logic [15:0] min_pulse_us;
		logic [15:0] max_pulse_us;
		logic [15:0] home_value;
		logic [10:0] update_rate_hz;
	} cfg_t;

	typedef struct packed {
		logic load_in;   // request accepted, latch value; update last value if it emits
		logic mul;       // span product
		logic div;       // reciprocal multiply
		logic pw;        // pulse width and rate product
		logic tlo;       // tick partial product, low half
		logic thi;       // tick partial product, high half
		logic load_out;  // result into output register
	} cmd_t;

	typedef struct packed {
		logic emit;      // incoming request produces a result
		logic scaled;
		logic out_busy;  // output register full and stalled
	} stat_t;

endpackage

`default_nettype wire

/* hw/rtl/sps_regs.sv */
// sps_regs: configuration register file behind the apb-style port
// depends on sps_pkg
`default_nettype none

module sps_regs (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sps_pkg::DATA_W-1:0] pwdata,
	output logic      [sps_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	output sps_pkg::cfg_t                   cfg
);
	import sps_pkg::*;

	cfg_t                 cfg_q;
	logic [REG_IDX_W-1:0] idx;
	logic                 wr_en;

	assign idx    = paddr[ADDR_W-1:2];
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.enabled        <= RST_ENABLED;
			cfg_q.wide_mode      <= RST_WIDE_MODE;
			cfg_q.reversed       <= RST_REVERSED;
			cfg_q.scaled         <= RST_SCALED;
			cfg_q.min_pulse_us   <= RST_MIN_US;
			cfg_q.max_pulse_us   <= RST_MAX_US;
			cfg_q.home_value     <= RST_HOME;
			cfg_q.update_rate_hz <= RST_RATE;
		end else if (wr_en) begin
			case (idx)
				REG_ENABLED:   cfg_q.enabled        <= pwdata[0];
				REG_WIDE_MODE: cfg_q.wide_mode      <= pwdata[0];
				REG_REVERSED:  cfg_q.reversed       <= pwdata[0];
				REG_SCALED:    cfg_q.scaled         <= pwdata[0];
				REG_MIN_US:    cfg_q.min_pulse_us   <= pwdata[15:0];
				REG_MAX_US:    cfg_q.max_pulse_us   <= pwdata[15:0];
				REG_HOME:      cfg_q.home_value     <= pwdata[15:0];
				REG_RATE:      cfg_q.update_rate_hz <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		case (idx)
			REG_ENABLED:   prdata[0]    = cfg_q.enabled;
			REG_WIDE_MODE: prdata[0]    = cfg_q.wide_mode;
			REG_REVERSED:  prdata[0]    = cfg_q.reversed;
			REG_SCALED:    prdata[0]    = cfg_q.scaled;
			REG_MIN_US:    prdata[15:0] = cfg_q.min_pulse_us;
			REG_MAX_US:    prdata[15:0] = cfg_q.max_pulse_us;
			REG_HOME:      prdata[15:0] = cfg_q.home_value;
			REG_RATE:      prdata[10:0] = cfg_q.update_rate_hz;
			default:       prdata       = '0;
		endcase
	end

endmodule

`default_nettype wire

/* hw/rtl/sps_ctrl.sv */
// sps_ctrl: sequencer that steps one request through the scaling datapath
// depends on sps_pkg; drives cmd_t to sps_dp and reads its stat_t
`default_nettype none

module sps_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	output logic                in_stall,
	input  wire sps_pkg::stat_t st,
	output sps_pkg::cmd_t       cmd
);
	import sps_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_PW,
		ST_TLO,
		ST_THI,
		ST_LOAD
	} state_t;

	state_t state_q;
	logic   in_stall_q;
	logic   accept;

	assign accept   = in_valid && !in_stall_q;
	assign in_stall = in_stall_q;

	always_comb begin
		cmd          = '0;
		cmd.load_in  = (state_q == ST_IDLE) && accept;
		cmd.mul      = (state_q == ST_MUL);
		cmd.div      = (state_q == ST_DIV);
		cmd.pw       = (state_q == ST_PW);
		cmd.tlo      = (state_q == ST_TLO);
		cmd.thi      = (state_q == ST_THI);
		cmd.load_out = (state_q == ST_LOAD) && !st.out_busy;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			in_stall_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept && st.emit) begin
						state_q    <= st.scaled ? ST_MUL : ST_LOAD;
						in_stall_q <= 1'b1;
					end
				end
				ST_MUL: state_q <= ST_DIV;
				ST_DIV: state_q <= ST_PW;
				ST_PW:  state_q <= ST_TLO;
				ST_TLO: state_q <= ST_THI;
				ST_THI: state_q <= ST_LOAD;
				ST_LOAD: begin
					if (!st.out_busy) begin
						state_q    <= ST_IDLE;
						in_stall_q <= 1'b0;
					end
				end
				default: begin
					state_q    <= ST_IDLE;
					in_stall_q <= 1'b0;
				end
			endcase
		end
	end

	a_stall_tracks_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall_q == (state_q != ST_IDLE))
		else $error("stall out of step with sequencer state");

	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_IDLE && !(in_valid && st.emit) |=> state_q == ST_IDLE)
		else $error("sequencer left idle without an emitting request");

	a_load_waits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_LOAD && st.out_busy |=> state_q == ST_LOAD)
		else $error("result dropped while output stalled");

endmodule

`default_nettype wire

/* hw/rtl/sps_dp.sv */
// sps_dp: value select, repeat filter, range map, tick conversion and output register
// depends on sps_pkg; stepped by cmd_t from sps_ctrl
`default_nettype none

module sps_dp (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire sps_pkg::cfg_t  cfg,
	input  wire sps_pkg::cmd_t  cmd,
	output sps_pkg::stat_t      st,
	input  wire logic [7:0]     low_byte,
	input  wire logic [7:0]     high_byte,
	output logic                out_valid,
	input  wire logic           out_stall,
	output logic [15:0]         pwm_off_count
);
	import sps_pkg::*;

	logic [15:0] v_in, v_sub;
	logic [15:0] v_q;
	logic [15:0] last_value_q;
	logic        last_valid_q;
	logic        out_valid_q;
	logic [15:0] out_q;

	logic [16:0] span, x, d;
	logic [15:0] ax, ad;
	logic [31:0] mag_q;
	logic        neg_q;
	logic [31:0] recip;
	logic [63:0] prod;
	logic [15:0] q_q;
	logic [15:0] q_signed, pw;
	logic [26:0] p_q;
	logic [43:0] pp_lo_q, pp_hi_q;
	logic [60:0] tsum;
	logic [15:0] ticks;

	// frame value, zero replaced by home
	assign v_in  = cfg.wide_mode ? {high_byte, low_byte} : {8'd0, low_byte};
	assign v_sub = (v_in == 16'd0) ? cfg.home_value : v_in;

	assign st.emit     = cfg.enabled && !(last_valid_q && (v_sub == last_value_q));
	assign st.scaled   = cfg.scaled;
	assign st.out_busy = out_valid_q && out_stall;

	// reversed map: (v - span) * d / -span == (span - v) * d / span, truncated toward zero
	assign span = cfg.wide_mode ? SPAN_WIDE : SPAN_NARROW;
	assign x    = cfg.reversed ? (span - {1'b0, v_q}) : {1'b0, v_q};
	assign d    = {1'b0, cfg.max_pulse_us} - {1'b0, cfg.min_pulse_us};
	assign ax   = x[16] ? 16'(17'd0 - x) : x[15:0];
	assign ad   = d[16] ? 16'(17'd0 - d) : d[15:0];

	assign recip = cfg.wide_mode ? RECIP_WIDE : RECIP_NARROW;
	assign prod  = 64'(mag_q) * 64'(recip);

	assign q_signed = neg_q ? 16'(16'd0 - q_q) : q_q;
	assign pw       = q_signed + cfg.min_pulse_us;

	assign tsum  = {pp_hi_q, {TICK_LO_W{1'b0}}} + 61'(pp_lo_q);
	assign ticks = tsum[TICK_SHIFT +: 16];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_value_q <= '0;
			last_valid_q <= 1'b0;
		end else if (cmd.load_in && st.emit) begin
			last_value_q <= v_sub;
			last_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			v_q <= v_sub;
		end
		if (cmd.mul) begin
			mag_q <= 32'(ax) * 32'(ad);
			neg_q <= x[16] ^ d[16];
		end
		if (cmd.div) begin
			q_q <= cfg.wide_mode ? prod[SHIFT_WIDE +: 16] : prod[SHIFT_NARROW +: 16];
		end
		if (cmd.pw) begin
			p_q <= 27'(pw) * 27'(cfg.update_rate_hz);
		end
		if (cmd.tlo) begin
			pp_lo_q <= 44'(p_q) * 44'(TICK_RECIP_LO);
		end
		if (cmd.thi) begin
			pp_hi_q <= 44'(p_q) * 44'(TICK_RECIP_HI);
		end
		if (cmd.load_out) begin
			out_q <= cfg.scaled ? ticks : v_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid     = out_valid_q;
	assign pwm_off_count = out_q;

	a_last_update: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_in && st.emit |=> last_valid_q && last_value_q == $past(v_sub))
		else $error("repeat filter not updated on emitting request");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> !st.out_busy)
		else $error("output register loaded while stalled");

	a_raw_pass: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out && !cfg.scaled |=> out_q == $past(v_q))
		else $error("unscaled result differs from value");

endmodule

`default_nettype wire

/* hw/rtl/servo_pulse_scaler_unit.sv */
// One servo channel: a request carries a frame value as low and high byte; zero takes the home
// value, a value equal to the last one sent gives no result, and a new value is either passed
// raw or mapped onto min..max microseconds and converted to ticks of a 4096-tick period at
// update_rate_hz. Requests that give no result leave the sequencer idle and unstalled. A
// raw result goes from acceptance straight to the output load; a scaled result first passes the
// chain of multiplies (span product, reciprocal divide, rate product, two tick partial products)
// that the sequencer steps one per cycle. The output register lets a new request in while the
// previous result still waits downstream.
// depends on sps_pkg, sps_regs, sps_ctrl, sps_dp
`default_nettype none

module servo_pulse_scaler_unit (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       psel,
	input  wire logic                       penable,
	input  wire logic                       pwrite,
	input  wire logic [sps_pkg::ADDR_W-1:0] paddr,
	input  wire logic [sps_pkg::DATA_W-1:0] pwdata,
	output logic      [sps_pkg::DATA_W-1:0] prdata,
	output logic                            pready,
	input  wire logic                       in_valid,
	output logic                            in_stall,
	input  wire logic [7:0]                 low_byte,
	input  wire logic [7:0]                 high_byte,
	output logic                            out_valid,
	input  wire logic                       out_stall,
	output logic [15:0]                     pwm_off_count
);
	import sps_pkg::*;

	cfg_t  cfg;
	cmd_t  cmd;
	stat_t st;

	sps_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	sps_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.st       (st),
		.cmd      (cmd)
	);

	sps_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg           (cfg),
		.cmd           (cmd),
		.st            (st),
		.low_byte      (low_byte),
		.high_byte     (high_byte),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.pwm_off_count (pwm_off_count)
	);

endmodule

`default_nettype wire
